// ===== design/cgd_pkg.sv =====
package cgd_pkg;

	localparam int SCORE_W = 16;
	localparam int LABEL_W = 13;

	localparam int MAX_CLASSES_DEF = 8192;
	localparam int QUEUE_DEPTH_DEF = 4;

	// One queued entry holds everything a closed step asks the output side to send.
	typedef struct packed {
		logic               has_label;
		logic [LABEL_W-1:0] label;
		logic               has_end;
	} entry_t;

endpackage

// ===== design/ctc_greedy_decoder_core.sv =====
// Greedy CTC decoder. Class scores (signed Q8.8) enter one per beat, class by
// class within a time step, with step_end on the last class of a step and
// sequence_end on the last step of a sequence (sequence_end also closes the step).
// For each step the first class with the highest score wins; a winner other than
// the blank class 0 that differs from the previous step's winner comes out as a
// label beat, and a sequence that produced a label ends with one end-marker beat
// (label_index 0, text_end 1); run_last marks the last beat that an input beat
// caused. Scores are taken at one per clock: the running maximum is a single
// compare and update per score. Result beats leave at one per clock while out_stall is low,
// from a registered output; a step that closes a sequence can cause two beats, and a
// queue of QUEUE_DEPTH entries between the scoring side and the output side
// absorbs this, so input stalls only while that queue is full. Classes past
// MAX_CLASSES in one step are ignored.
module ctc_greedy_decoder_core #(
	parameter int MAX_CLASSES = cgd_pkg::MAX_CLASSES_DEF,
	parameter int QUEUE_DEPTH = cgd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [cgd_pkg::SCORE_W-1:0] class_score,
	input  logic                               step_end,
	input  logic                               sequence_end,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic        [cgd_pkg::LABEL_W-1:0] label_index,
	output logic                               text_end,
	output logic                               run_last
);

	logic            accept;
	logic            push;
	cgd_pkg::entry_t push_entry;
	logic            full;
	logic            pop;
	logic            head_valid;
	cgd_pkg::entry_t head_entry;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	cgd_front #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.class_score  (class_score),
		.step_end     (step_end),
		.sequence_end (sequence_end),
		.push         (push),
		.push_entry   (push_entry)
	);

	cgd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	cgd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_entry  (head_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.label_index (label_index),
		.text_end    (text_end),
		.run_last    (run_last)
	);

endmodule

// ===== design/cgd_front.sv =====
module cgd_front #(
	parameter int MAX_CLASSES = cgd_pkg::MAX_CLASSES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic signed [cgd_pkg::SCORE_W-1:0]   class_score,
	input  logic                                 step_end,
	input  logic                                 sequence_end,
	output logic                                 push,
	output cgd_pkg::entry_t                      push_entry
);

	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam int CLS_W = $clog2(MAX_CLASSES);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CLASSES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CLASSES - 1);

	logic        [CNT_W-1:0]            cnt_q;
	logic signed [cgd_pkg::SCORE_W-1:0] best_score_q;
	logic        [CLS_W-1:0]            best_class_q;
	logic        [CLS_W-1:0]            prev_winner_q;
	logic                               any_q;

	logic             first;
	logic             active;
	logic             take;
	logic [CLS_W-1:0] cand_class;
	logic [CLS_W-1:0] winner;
	logic             step_done;
	logic             emit_label;
	logic             any_now;
	logic             emit_end;

	always_comb begin
		first      = (cnt_q == '0);
		active     = !first && (cnt_q < CNT_MAX);
		take       = first || (active && (class_score > best_score_q));
		cand_class = first ? '0 : cnt_q[CLS_W-1:0];
		winner     = take ? cand_class : best_class_q;
		step_done  = step_end || sequence_end;
		emit_label = step_done && (winner != '0) && (winner != prev_winner_q);
		any_now    = any_q || emit_label;
		emit_end   = sequence_end && any_now;
	end

	assign push                 = accept && (emit_label || emit_end);
	assign push_entry.has_label = emit_label;
	assign push_entry.label     = cgd_pkg::LABEL_W'(winner);
	assign push_entry.has_end   = emit_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			best_score_q  <= '0;
			best_class_q  <= '0;
			prev_winner_q <= '0;
			any_q         <= 1'b0;
		end else if (accept) begin
			if (step_done) begin
				cnt_q         <= '0;
				best_score_q  <= '0;
				best_class_q  <= '0;
				prev_winner_q <= sequence_end ? '0 : winner;
				any_q         <= sequence_end ? 1'b0 : any_now;
			end else begin
				if (take) begin
					best_score_q <= class_score;
					best_class_q <= cand_class;
				end
				// Once the last class index is used the counter parks at the class
				// count, and further scores of the step are ignored.
				if (first) begin
					cnt_q <= CNT_W'(1);
				end else if (active) begin
					cnt_q <= (cnt_q < CNT_LAST) ? cnt_q + CNT_W'(1) : CNT_MAX;
				end
			end
		end
	end

	a_winner_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (CNT_W'(best_class_q) < cnt_q))
		else $error("best class is beyond the classes seen in this step");

	a_end_needs_label: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_entry.has_end && !push_entry.has_label) |-> any_q)
		else $error("end marker queued for a sequence with no label");

	a_seq_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sequence_end) |=> (!any_q && (prev_winner_q == '0) && (cnt_q == '0)))
		else $error("sequence end did not clear the sequence state");

endmodule

// ===== design/cgd_queue.sv =====
module cgd_queue #(
	parameter int DEPTH = cgd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cgd_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output cgd_pkg::entry_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

	cgd_pkg::entry_t        slots_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full       = (count_q == CNT_DEPTH);
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("entry pushed into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_DEPTH)
		else $error("queue count out of range");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not follow a push");

endmodule

// ===== design/cgd_back.sv =====
module cgd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  cgd_pkg::entry_t             head_entry,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cgd_pkg::LABEL_W-1:0] label_index,
	output logic                        text_end,
	output logic                        run_last
);

	logic                        out_valid_q;
	logic [cgd_pkg::LABEL_W-1:0] label_q;
	logic                        text_end_q;
	logic                        run_last_q;
	logic                        label_sent_q;

	logic load;
	logic label_beat;

	// The output register takes a new beat whenever it is empty or its beat leaves.
	assign load       = !out_valid_q || !out_stall;
	assign label_beat = head_entry.has_label && !label_sent_q;
	// An entry with a label and an end marker stays at the head until its end marker is loaded.
	assign pop        = load && head_valid && !(label_beat && head_entry.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			label_sent_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				label_sent_q <= label_beat && head_entry.has_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			if (label_beat) begin
				label_q    <= head_entry.label;
				text_end_q <= 1'b0;
				run_last_q <= !head_entry.has_end;
			end else begin
				label_q    <= '0;
				text_end_q <= 1'b1;
				run_last_q <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign label_index = label_q;
	assign text_end    = text_end_q;
	assign run_last    = run_last_q;

	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && text_end_q) |-> (run_last_q && (label_q == '0)))
		else $error("end marker beat malformed");

	a_marker_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !run_last_q) |=> (out_valid_q && text_end_q))
		else $error("label beat not followed by its end marker");

	a_label_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !text_end_q) |-> (label_q != '0))
		else $error("label beat carries the blank class");

endmodule

// ===== dv/tb_ctc_greedy_decoder_core.sv =====
module tb_ctc_greedy_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCORE_W = cgd_pkg::SCORE_W;
	localparam int LABEL_W = cgd_pkg::LABEL_W;
	localparam int MAX_CLS = cgd_pkg::MAX_CLASSES_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_BEATS = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
	typedef enum int {MIX_RANDOM, MIX_NEAR_TIE, MIX_PLANTED, MIX_FLAT} score_mix_t;

	// Tracks the best path through the score stream and holds the label beats
	// that the accepted scores have made due.
	class best_path_tracker;
		typedef struct {
			logic [LABEL_W-1:0] label;
			logic               text_end;
			logic               run_last;
		} label_beat_t;

		label_beat_t               labels_due[$];
		logic [LABEL_W:0]          cls_count;
		logic signed [SCORE_W-1:0] best_score;
		logic [LABEL_W-1:0]        best_cls;
		logic [LABEL_W-1:0]        prev_winner;
		logic                      any_label;
		int errors, beats_in, labels_out, markers_out, saturated_steps;

		function new();
			cls_count = '0;
			best_score = '0;
			best_cls = '0;
			prev_winner = '0;
			any_label = 1'b0;
			errors = 0;
			beats_in = 0;
			labels_out = 0;
			markers_out = 0;
			saturated_steps = 0;
		endfunction

		function void take_score(logic signed [SCORE_W-1:0] score, logic se, logic qe);
			logic               closing;
			logic [LABEL_W-1:0] winner;
			logic               emit_label;
			logic               emit_end;
			label_beat_t        beat;
			closing = se | qe;
			emit_label = 1'b0;
			emit_end = 1'b0;
			winner = '0;
			beats_in++;
			if (cls_count == 0) begin
				best_score = score;
				best_cls = '0;
				cls_count = (LABEL_W+1)'(1);
			end else if (cls_count < MAX_CLS) begin
				if (score > best_score) begin
					best_score = score;
					best_cls = cls_count[LABEL_W-1:0];
				end
				// Past the last countable class the counter parks at MAX_CLS and
				// the rest of the step is ignored.
				if (cls_count < MAX_CLS - 1)
					cls_count++;
				else
					cls_count = (LABEL_W+1)'(MAX_CLS);
			end
			if (closing) begin
				if (cls_count == MAX_CLS)
					saturated_steps++;
				winner = best_cls;
				emit_label = (winner != 0) && (winner != prev_winner);
				if (emit_label)
					any_label = 1'b1;
				prev_winner = winner;
				cls_count = '0;
				best_score = '0;
				best_cls = '0;
				if (qe) begin
					emit_end = any_label;
					prev_winner = '0;
					any_label = 1'b0;
				end
			end
			if (emit_label) begin
				beat = '{label: winner, text_end: 1'b0, run_last: !emit_end};
				labels_due.insert(labels_due.size(), beat);
			end
			if (emit_end) begin
				beat = '{label: '0, text_end: 1'b1, run_last: 1'b1};
				labels_due.insert(labels_due.size(), beat);
			end
		endfunction

		function void check_result(logic [LABEL_W-1:0] label, logic te, logic rl);
			label_beat_t want;
			if (labels_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat label_index=%0d text_end=%0b run_last=%0b",
					$time, label, te, rl);
				return;
			end
			want = labels_due.pop_front();
			if (label !== want.label) begin
				errors++;
				$display("%0t: label_index mismatch, expected %0d, got %0d",
					$time, want.label, label);
			end
			if (te !== want.text_end) begin
				errors++;
				$display("%0t: text_end mismatch, expected %0b, got %0b",
					$time, want.text_end, te);
			end
			if (rl !== want.run_last) begin
				errors++;
				$display("%0t: run_last mismatch, expected %0b, got %0b",
					$time, want.run_last, rl);
			end
			if (want.text_end)
				markers_out++;
			else
				labels_out++;
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [SCORE_W-1:0] class_score;
	logic                      step_end;
	logic                      sequence_end;
	logic                      out_valid;
	logic                      out_stall;
	logic [LABEL_W-1:0]        label_index;
	logic                      text_end;
	logic                      run_last;

	best_path_tracker tracker = new();

	int  cycles = 0;
	int  input_stall_cycles = 0;
	int  beats_sent = 0;
	int  burst_left = 0;
	bit  steady = 1'b0;
	int  hold_reqs = 0;
	int  holds_done = 0;

	ctc_greedy_decoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.class_score  (class_score),
		.step_end     (step_end),
		.sequence_end (sequence_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.label_index  (label_index),
		.text_end     (text_end),
		.run_last     (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall)
				input_stall_cycles++;
			if (in_valid && !in_stall)
				tracker.take_score(class_score, step_end, sequence_end);
			if (out_valid && !out_stall)
				tracker.check_result(label_index, text_end, run_last);
		end
	end

	// Receiver: stall pattern changes now and then; a requested hold keeps the
	// output stalled long enough for the block to back up into its input.
	initial begin
		stall_mode_t mode;
		int          mode_left;
		mode = STALL_NONE;
		mode_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_reqs) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(32, 200);
				end
				mode_left--;
				case (mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
					default: out_stall <= ((mode_left % 4) == 0);
				endcase
			end
		end
	end

	// Offers one beat, starting and ending at a falling edge. Outside steady
	// stretches the beats come in bursts with random gaps between them.
	task automatic offer(logic signed [SCORE_W-1:0] s, logic se, logic qe);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		class_score <= s;
		step_end <= se;
		sequence_end <= qe;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.labels_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// Two-class steps whose winner alternates between class 1 and the blank,
	// so every other step makes a label beat while the output is held.
	task automatic fill_under_hold();
		hold_reqs++;
		steady = 1'b1;
		for (int t = 0; t < 30; t++) begin
			offer(16'sd0, 1'b0, 1'b0);
			offer((t % 2 == 0) ? 16'sd64 : -16'sd64, 1'b1, t == 29);
		end
		steady = 1'b0;
	endtask

	task automatic random_sequence();
		int                        n_steps;
		int                        n_cls;
		int                        fav;
		int                        win;
		score_mix_t                mix;
		logic signed [SCORE_W-1:0] s;
		logic signed [SCORE_W-1:0] flat;
		logic                      se;
		logic                      qe;
		logic                      last;
		n_steps = $urandom_range(1, 6);
		fav = $urandom_range(0, 3);
		for (int t = 0; t < n_steps; t++) begin
			n_cls = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
			mix = score_mix_t'($urandom_range(0, 3));
			// A favorite class that wins again and again gives merged repeats.
			win = ($urandom_range(0, 2) == 0) ? fav % n_cls : $urandom_range(0, n_cls - 1);
			flat = 16'($urandom());
			for (int k = 0; k < n_cls; k++) begin
				case (mix)
					MIX_RANDOM: s = 16'($urandom());
					MIX_NEAR_TIE: s = 16'($urandom_range(0, 4)) - 16'sd2;
					MIX_PLANTED: s = (k == win) ? {1'b0, 15'($urandom())}
						: {1'b1, 15'($urandom())};
					default: s = flat;
				endcase
				last = (k == n_cls - 1);
				qe = last && (t == n_steps - 1);
				se = last && !(qe && $urandom_range(0, 3) == 0);
				// Occasional stray markers break steps and sequences in odd places.
				if (!last && $urandom_range(0, 59) == 0)
					se = 1'b1;
				if (!last && $urandom_range(0, 99) == 0)
					qe = 1'b1;
				offer(s, se, qe);
			end
		end
	endtask

	initial begin
		int  random_start;
		bit  mid_done;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		class_score <= '0;
		step_end <= 1'b0;
		sequence_end <= 1'b0;
		mid_done = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A lone blank class closes a sequence that decodes to nothing.
		offer(-16'sd32768, 1'b1, 1'b1);
		// Score extremes: the top score makes class 1 the winner.
		offer(-16'sd32768, 1'b0, 1'b0);
		offer(16'sd32767, 1'b1, 1'b0);
		// The same winner in the next step is merged away.
		offer(16'sd0, 1'b0, 1'b0);
		offer(16'sd100, 1'b1, 1'b0);
		// All tied, so the blank keeps it; the sequence end alone closes the step.
		offer(16'sd5, 1'b0, 1'b0);
		offer(16'sd5, 1'b0, 1'b0);
		offer(16'sd5, 1'b0, 1'b1);
		// A tie at the top goes to the lower class index.
		offer(16'sd1, 1'b0, 1'b0);
		offer(16'sd3, 1'b0, 1'b0);
		offer(16'sd3, 1'b1, 1'b0);
		// A label and the end marker from one beat.
		offer(16'sd0, 1'b0, 1'b0);
		offer(-16'sd1, 1'b0, 1'b0);
		offer(16'sd7, 1'b1, 1'b1);
		// A blank between two equal winners lets the second one through.
		offer(16'sd9, 1'b0, 1'b0);
		offer(16'sd1, 1'b1, 1'b0);
		offer(16'sd0, 1'b0, 1'b0);
		offer(16'sd9, 1'b1, 1'b0);
		offer(16'sd9, 1'b0, 1'b0);
		offer(16'sd0, 1'b1, 1'b0);
		offer(16'sd0, 1'b0, 1'b0);
		offer(16'sd9, 1'b1, 1'b1);

		fill_under_hold();
		drain();

		random_start = beats_sent;
		while (beats_sent - random_start < RANDOM_BEATS) begin
			random_sequence();
			if (!mid_done && beats_sent - random_start >= RANDOM_BEATS / 2) begin
				mid_done = 1'b1;
				fill_under_hold();
				drain();
			end
		end

		drain();
		$display("Decoded %0d score beats, %0d steps past the class limit, %0d input stall cycles.",
			tracker.beats_in, tracker.saturated_steps, input_stall_cycles);
		$display("Checked %0d labels and %0d end markers, %0d mismatches, %0d beats still due.",
			tracker.labels_out, tracker.markers_out, tracker.errors, tracker.labels_due.size());
		if (tracker.errors == 0 && tracker.labels_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
